// ----- src/bsel_pkg.sv -----
// Shared types and constants for the backend selector.
package bsel_pkg;

	localparam int DEF_MAX_POOL = 8;

	localparam int ACT_W   = 2;
	localparam int IDX_W   = 3;
	localparam int HLTH_W  = 2;
	localparam int CONN_W  = 16;
	localparam int MASK_W  = 8;
	localparam int STS_W   = 2;
	localparam int CNT_W   = 4;
	localparam int RR_W    = 64;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 4;

	localparam logic [ACT_W-1:0] ACT_SELECT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_HEALTH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CONN   = 2'd2;

	localparam logic [STS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STS_W-1:0] ST_NONE  = 2'd1;
	localparam logic [STS_W-1:0] ST_RANGE = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_STRATEGY = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_COUNT    = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_BREAKER  = 2'd2;

	localparam logic [HLTH_W-1:0] HEALTH_UP = 2'd0;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic walk_init;
		logic walk_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic needs_walk;
		logic least_conn;
		logic div_last;
		logic walk_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ----- src/bsel_ctrl.sv -----
// Controller state machine that sequences the division, the walk and the result.
module bsel_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bsel_pkg::dp_sts_t sts,
	output bsel_pkg::dp_cmd_t cmd
);
	import bsel_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_WINIT = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (!sts.needs_walk) begin
					state_d = S_FIN;
				end else if (sts.least_conn) begin
					state_d = S_WINIT;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_WINIT;
				end
			end
			S_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d       = S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/bsel_dp.sv -----
// Datapath: configuration, backend tables, round-robin counter, serial modulo and walk.
module bsel_dp #(
	parameter int MAX_POOL = bsel_pkg::DEF_MAX_POOL
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [bsel_pkg::CFG_IW-1:0] cfg_index,
	input  logic [bsel_pkg::CFG_DW-1:0] cfg_data,
	input  logic [bsel_pkg::ACT_W-1:0]  action,
	input  logic [bsel_pkg::IDX_W-1:0]  backend_index,
	input  logic [bsel_pkg::HLTH_W-1:0] new_health,
	input  logic [bsel_pkg::CONN_W-1:0] active_count,
	input  logic [bsel_pkg::MASK_W-1:0] circuit_open_mask,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        granted,
	output logic [bsel_pkg::IDX_W-1:0]  chosen_index,
	output logic [bsel_pkg::STS_W-1:0]  status,
	input  bsel_pkg::dp_cmd_t           cmd,
	output bsel_pkg::dp_sts_t           sts
);
	import bsel_pkg::*;

	localparam int TBL_DEPTH = (MAX_POOL < 8) ? MAX_POOL : 8;
	localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int DSTEP_W   = $clog2(RR_W);

	logic              strategy_q;
	logic [CNT_W-1:0]  count_q;
	logic              breaker_q;

	logic [ACT_W-1:0]  act_q;
	logic [IDX_W-1:0]  idx_q;
	logic [HLTH_W-1:0] hlth_q;
	logic [CONN_W-1:0] conn_in_q;
	logic [MASK_W-1:0] mask_q;

	logic [HLTH_W-1:0] health_q [TBL_DEPTH];
	logic [CONN_W-1:0] conn_q   [TBL_DEPTH];

	logic [RR_W-1:0]    rr_q;
	logic [RR_W-1:0]    dividend_q;
	logic [CNT_W-1:0]   rem_q;
	logic [DSTEP_W-1:0] dstep_q;

	logic [CNT_W-1:0]  walk_i_q;
	logic [CNT_W-1:0]  walk_k_q;
	logic [RR_W-1:0]   val_q;
	logic              found_q;
	logic [CNT_W-1:0]  best_idx_q;
	logic [CONN_W-1:0] best_val_q;

	logic              out_valid_q;
	logic              granted_q;
	logic [IDX_W-1:0]  chosen_q;
	logic [STS_W-1:0]  status_q;

	logic [CNT_W-1:0]  pool_n;
	logic              in_tbl;
	logic [TBL_AW-1:0] rd_addr;
	logic [HLTH_W-1:0] cur_health;
	logic [CONN_W-1:0] cur_conn;
	logic              cur_open;
	logic              usable;
	logic              take;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    trial_sub;
	logic [CNT_W-1:0]  next_i;
	logic              is_select;
	logic              wr_ok;

	assign pool_n = ({3'b000, count_q} > 7'(MAX_POOL)) ? CNT_W'(MAX_POOL) : count_q;

	assign in_tbl     = ({3'b000, walk_i_q} < 7'(TBL_DEPTH));
	assign rd_addr    = walk_i_q[TBL_AW-1:0];
	assign cur_health = in_tbl ? health_q[rd_addr] : HEALTH_UP;
	assign cur_conn   = in_tbl ? conn_q[rd_addr] : '0;
	assign cur_open   = (walk_i_q < CNT_W'(MASK_W)) ? mask_q[walk_i_q[IDX_W-1:0]] : 1'b0;
	assign usable     = (cur_health == HEALTH_UP) && !(breaker_q && cur_open);

	assign take = usable && (strategy_q ? (!found_q || (cur_conn < best_val_q)) : !found_q);

	assign trial     = {rem_q, dividend_q[RR_W-1]};
	assign trial_sub = trial - {1'b0, pool_n};

	always_comb begin
		if (strategy_q) begin
			next_i = walk_i_q + 1'b1;
		end else if (val_q == '1) begin
			next_i = '0;
		end else if (walk_i_q == pool_n - 1'b1) begin
			next_i = '0;
		end else begin
			next_i = walk_i_q + 1'b1;
		end
	end

	assign is_select = (act_q == ACT_SELECT);
	assign wr_ok     = ({1'b0, idx_q} < pool_n) && ({4'b0000, idx_q} < 7'(TBL_DEPTH));

	assign sts.needs_walk = is_select && (pool_n != '0);
	assign sts.least_conn = strategy_q;
	assign sts.div_last   = (dstep_q == '1);
	assign sts.walk_last  = (walk_k_q == pool_n - 1'b1);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign chosen_index = chosen_q;
	assign status       = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= 1'b0;
			count_q    <= '0;
			breaker_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STRATEGY: strategy_q <= cfg_data[0];
				CFG_COUNT:    count_q    <= cfg_data;
				CFG_BREAKER:  breaker_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TBL_DEPTH; i++) begin
				health_q[i] <= HEALTH_UP;
				conn_q[i]   <= '0;
			end
			rr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				if (is_select && (pool_n != '0) && !strategy_q) begin
					rr_q <= rr_q + 1'b1;
				end
				if (wr_ok && (act_q == ACT_HEALTH)) begin
					health_q[idx_q[TBL_AW-1:0]] <= hlth_q;
				end
				if (wr_ok && (act_q == ACT_CONN)) begin
					conn_q[idx_q[TBL_AW-1:0]] <= conn_in_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q     <= action;
			idx_q     <= backend_index;
			hlth_q    <= new_health;
			conn_in_q <= active_count;
			mask_q    <= circuit_open_mask;
		end
		if (cmd.div_init) begin
			dividend_q <= rr_q;
			rem_q      <= '0;
			dstep_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q      <= trial_sub[CNT_W] ? trial[CNT_W-1:0] : trial_sub[CNT_W-1:0];
			dividend_q <= {dividend_q[RR_W-2:0], 1'b0};
			dstep_q    <= dstep_q + 1'b1;
		end
		if (cmd.walk_init) begin
			walk_i_q <= strategy_q ? '0 : rem_q;
			walk_k_q <= '0;
			val_q    <= rr_q;
			found_q  <= 1'b0;
		end else if (cmd.walk_step) begin
			walk_i_q <= next_i;
			walk_k_q <= walk_k_q + 1'b1;
			val_q    <= val_q + 1'b1;
			if (take) begin
				found_q    <= 1'b1;
				best_idx_q <= walk_i_q;
				best_val_q <= cur_conn;
			end
		end
		if (cmd.finish) begin
			if (is_select) begin
				if ((pool_n != '0) && found_q) begin
					granted_q <= 1'b1;
					chosen_q  <= best_idx_q[IDX_W-1:0];
					status_q  <= ST_OK;
				end else begin
					granted_q <= 1'b0;
					chosen_q  <= '0;
					status_q  <= ST_NONE;
				end
			end else begin
				granted_q <= 1'b0;
				chosen_q  <= '0;
				if (((act_q == ACT_HEALTH) || (act_q == ACT_CONN)) && !wr_ok) begin
					status_q <= ST_RANGE;
				end else begin
					status_q <= ST_OK;
				end
			end
		end
	end

endmodule

// ----- src/backend_selector_rr_least_conn.sv -----
// Top level of the backend selector: round robin and least connections.
// Each transaction takes one select, health write or connection-count write and returns one
// result. A write or an empty-pool select goes from acceptance through a decode state to the
// finish state; a least connections select walks the pool, one backend per cycle, and a round
// robin select first reduces the 64-bit counter modulo the effective pool size by bit-serial
// division (one bit per cycle) and then walks the pool. The finish state waits while the
// output register still holds an untaken result. The next transaction can be accepted in the
// same cycle in which the result appears.
module backend_selector_rr_least_conn #(
	parameter int MAX_POOL = bsel_pkg::DEF_MAX_POOL
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bsel_pkg::CFG_IW-1:0] cfg_index,
	input  logic [bsel_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bsel_pkg::ACT_W-1:0]  action,
	input  logic [bsel_pkg::IDX_W-1:0]  backend_index,
	input  logic [bsel_pkg::HLTH_W-1:0] new_health,
	input  logic [bsel_pkg::CONN_W-1:0] active_count,
	input  logic [bsel_pkg::MASK_W-1:0] circuit_open_mask,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        granted,
	output logic [bsel_pkg::IDX_W-1:0]  chosen_index,
	output logic [bsel_pkg::STS_W-1:0]  status
);
	import bsel_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	bsel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsel_dp #(
		.MAX_POOL (MAX_POOL)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.action            (action),
		.backend_index     (backend_index),
		.new_health        (new_health),
		.active_count      (active_count),
		.circuit_open_mask (circuit_open_mask),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.granted           (granted),
		.chosen_index      (chosen_index),
		.status            (status),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule
